/* hw/rtl/tbdpg_pkg.sv */
// Shared types and constants of the three-button debouncer with press guard.
package tbdpg_pkg;

   localparam int NUM_BUTTONS = 3;
   localparam int SNAP_WIDTH = 8;
   localparam int SEL_WIDTH = 3;
   localparam int TICK_WIDTH = 32;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_DATA_WIDTH-1:0] DEBOUNCE_RESET = 16'd100;
   localparam logic [CSR_DATA_WIDTH-1:0] GUARD_RESET = 16'd300;
   localparam logic [SEL_WIDTH-1:0] SEL_FIRST_RESET = 3'd0;
   localparam logic [SEL_WIDTH-1:0] SEL_SECOND_RESET = 3'd1;
   localparam logic [SEL_WIDTH-1:0] SEL_CANCEL_RESET = 3'd2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEBOUNCE_TICKS = 3'd0,
      CSR_GUARD_TICKS = 3'd1,
      CSR_SELECT_FIRST = 3'd2,
      CSR_SELECT_SECOND = 3'd3,
      CSR_SELECT_CANCEL = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [SNAP_WIDTH-1:0] snapshot;
      logic [TICK_WIDTH-1:0] now;
   } req_type;

   typedef struct packed {
      logic [NUM_BUTTONS-1:0] stable_buttons;
      logic [SNAP_WIDTH-1:0] stable_mask;
      logic [NUM_BUTTONS-1:0] press_events;
      logic [NUM_BUTTONS-1:0] release_events;
      logic [NUM_BUTTONS-1:0] guarded_presses;
   } rsp_type;

   typedef struct packed {
      logic stable;
      logic press;
      logic release_edge;
      logic guarded;
   } lane_out_type;

endpackage

/* hw/rtl/tbdpg_lane.sv */
// One debounce lane: candidate and stable levels, timers and press guard of one button.
module tbdpg_lane (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic started,
   input  logic raw,
   input  logic [tbdpg_pkg::TICK_WIDTH-1:0] now,
   input  logic [tbdpg_pkg::CSR_DATA_WIDTH-1:0] debounce_ticks,
   input  logic [tbdpg_pkg::CSR_DATA_WIDTH-1:0] guard_ticks,
   output tbdpg_pkg::lane_out_type lane_out
);
   import tbdpg_pkg::*;

   logic candidate_ff, candidate_in;
   logic stable_ff, stable_in;
   logic [TICK_WIDTH-1:0] cand_time_ff, cand_time_in;
   logic [TICK_WIDTH-1:0] last_press_ff, last_press_in;
   logic [TICK_WIDTH-1:0] held_ticks;
   logic [TICK_WIDTH-1:0] since_press;
   logic press, release_edge, guarded;

   assign held_ticks = now - cand_time_ff;
   assign since_press = now - last_press_ff;

   always_comb begin
      candidate_in = candidate_ff;
      stable_in = stable_ff;
      cand_time_in = cand_time_ff;
      last_press_in = last_press_ff;
      press = 1'b0;
      release_edge = 1'b0;
      guarded = 1'b0;
      priority if (!started) begin
         candidate_in = raw;
         stable_in = raw;
         cand_time_in = now;
      end else if (raw != candidate_ff) begin
         candidate_in = raw;
         cand_time_in = now;
      end else if ((candidate_ff != stable_ff) &&
                   (held_ticks >= {{(TICK_WIDTH-CSR_DATA_WIDTH){1'b0}}, debounce_ticks})) begin
         stable_in = candidate_ff;
         if (candidate_ff) begin
            if ((last_press_ff != '0) &&
                (since_press < {{(TICK_WIDTH-CSR_DATA_WIDTH){1'b0}}, guard_ticks})) begin
               guarded = 1'b1;
            end else begin
               last_press_in = now;
               press = 1'b1;
            end
         end else begin
            release_edge = 1'b1;
         end
      end else begin
         candidate_in = candidate_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         candidate_ff <= 1'b0;
         stable_ff <= 1'b0;
         cand_time_ff <= '0;
         last_press_ff <= '0;
      end else if (accept) begin
         candidate_ff <= candidate_in;
         stable_ff <= stable_in;
         cand_time_ff <= cand_time_in;
         last_press_ff <= last_press_in;
      end
   end

   assign lane_out.stable = stable_in;
   assign lane_out.press = press;
   assign lane_out.release_edge = release_edge;
   assign lane_out.guarded = guarded;

endmodule

/* hw/rtl/tbdpg_merge.sv */
// Merge stage: gathers the lane results into one response word and holds it for the receiver.
module tbdpg_merge (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  tbdpg_pkg::lane_out_type lane_out [tbdpg_pkg::NUM_BUTTONS],
   input  logic [tbdpg_pkg::SEL_WIDTH-1:0] sel [tbdpg_pkg::NUM_BUTTONS],
   input  logic rsp_ready,
   output logic rsp_valid,
   output tbdpg_pkg::rsp_type rsp_data
);
   import tbdpg_pkg::*;

   logic valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      data_in = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         data_in.stable_buttons[i] = lane_out[i].stable;
         data_in.press_events[i] = lane_out[i].press;
         data_in.release_events[i] = lane_out[i].release_edge;
         data_in.guarded_presses[i] = lane_out[i].guarded;
         if (lane_out[i].stable) begin
            data_in.stable_mask[sel[i]] = 1'b1;
         end
      end
   end

   always_comb begin
      priority if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

endmodule

/* hw/rtl/three_button_debouncer_with_press_guard_core.sv */
// Top level of the three-button debouncer with press guard.
//
// Each request word is one sample: an 8-bit input snapshot and the current
// 32-bit tick count. Three lanes debounce the first, second and cancel
// buttons, each picked from the snapshot by its select register, and the
// merge stage packs their levels and events into one response word.
// Every request word yields exactly one response word.
// A word accepted in one cycle is offered on the response channel in the
// next. Throughput is one word per cycle while the receiver takes words;
// it is set by the lane update and the one-word output register.
// When the receiver stalls, the response word holds and req_ready drops
// until it is taken; req_ready is high whenever the output register is empty
// or being emptied in the same cycle.
// The user must write configuration through csr_write_enable, csr_index and
// csr_write_data while the block is idle; it does not enforce this. Unknown
// indexes are ignored. Synchronous reset restores the register defaults, clears
// all lane state and the started flag, and empties the output register.
module three_button_debouncer_with_press_guard_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  tbdpg_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output tbdpg_pkg::rsp_type rsp_data,
   input  logic csr_write_enable,
   input  logic [tbdpg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tbdpg_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import tbdpg_pkg::*;

   logic [CSR_DATA_WIDTH-1:0] debounce_ff;
   logic [CSR_DATA_WIDTH-1:0] guard_ff;
   logic [SEL_WIDTH-1:0] sel_ff [NUM_BUTTONS];
   logic started_ff;
   logic accept;
   lane_out_type lane_out [NUM_BUTTONS];

   assign req_ready = !rsp_valid || rsp_ready;
   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         guard_ff <= GUARD_RESET;
         sel_ff[0] <= SEL_FIRST_RESET;
         sel_ff[1] <= SEL_SECOND_RESET;
         sel_ff[2] <= SEL_CANCEL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TICKS: debounce_ff <= csr_write_data;
            CSR_GUARD_TICKS: guard_ff <= csr_write_data;
            CSR_SELECT_FIRST: sel_ff[0] <= csr_write_data[SEL_WIDTH-1:0];
            CSR_SELECT_SECOND: sel_ff[1] <= csr_write_data[SEL_WIDTH-1:0];
            CSR_SELECT_CANCEL: sel_ff[2] <= csr_write_data[SEL_WIDTH-1:0];
            default: debounce_ff <= debounce_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else if (accept) begin
         started_ff <= 1'b1;
      end
   end

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      tbdpg_lane u_lane (
         .clock(clock),
         .reset(reset),
         .accept(accept),
         .started(started_ff),
         .raw(req_data.snapshot[sel_ff[i]]),
         .now(req_data.now),
         .debounce_ticks(debounce_ff),
         .guard_ticks(guard_ff),
         .lane_out(lane_out[i])
      );
   end

   tbdpg_merge u_merge (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .lane_out(lane_out),
      .sel(sel_ff),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

endmodule

/* hw/rtl/tbdpg_checker.sv */
// Port-level checker of the debouncer core and the bind that attaches it.
module tbdpg_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input tbdpg_pkg::rsp_type rsp_data
);
   import tbdpg_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response word changed or vanished.");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("Accepted request word produced no response word.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response offered right after reset.");

   a_event_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.press_events & ~rsp_data.stable_buttons) == '0) &&
                    ((rsp_data.guarded_presses & ~rsp_data.stable_buttons) == '0) &&
                    ((rsp_data.release_events & rsp_data.stable_buttons) == '0))
      else $error("Edge event disagrees with the stable level.");

   a_press_guard_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.press_events & rsp_data.guarded_presses) == '0)
      else $error("Press reported both accepted and guarded.");

endmodule

bind three_button_debouncer_with_press_guard_core tbdpg_checker u_tbdpg_checker (.*);

/* bench/tbdpg_button_checker.sv */
// Checker that predicts the debouncer's response words and compares them with the block.
`timescale 1ns / 100ps
module tbdpg_button_checker
   import tbdpg_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  rsp_type rsp_data,
   input  logic csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_write_data,
   output int error_count,
   output int pending_words
);

   logic [CSR_DATA_WIDTH-1:0] debounce_ticks_q;
   logic [CSR_DATA_WIDTH-1:0] guard_ticks_q;
   logic [SEL_WIDTH-1:0] button_sel [NUM_BUTTONS];
   logic started_q;
   logic [NUM_BUTTONS-1:0] cand_level;
   logic [NUM_BUTTONS-1:0] stable_level;
   logic [TICK_WIDTH-1:0] cand_time [NUM_BUTTONS];
   logic [TICK_WIDTH-1:0] last_press [NUM_BUTTONS];
   rsp_type button_reports [$];

   task automatic report_mismatch(input string text);
      $display("%0t: %s", $time, text);
      error_count++;
   endtask

   function automatic rsp_type debounce_sample(input req_type sample);
      rsp_type word;
      logic raw;
      logic [TICK_WIDTH-1:0] held_for;
      logic [TICK_WIDTH-1:0] since_press;
      word = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         raw = sample.snapshot[button_sel[b]];
         held_for = sample.now - cand_time[b];
         if (!started_q) begin
            cand_level[b] = raw;
            stable_level[b] = raw;
            cand_time[b] = sample.now;
         end else if (raw != cand_level[b]) begin
            cand_level[b] = raw;
            cand_time[b] = sample.now;
         end else if (cand_level[b] != stable_level[b] &&
                      held_for >= {16'd0, debounce_ticks_q}) begin
            stable_level[b] = cand_level[b];
            if (stable_level[b]) begin
               since_press = sample.now - last_press[b];
               if (last_press[b] != '0 && since_press < {16'd0, guard_ticks_q}) begin
                  word.guarded_presses[b] = 1'b1;
               end else begin
                  last_press[b] = sample.now;
                  word.press_events[b] = 1'b1;
               end
            end else begin
               word.release_events[b] = 1'b1;
            end
         end
      end
      started_q = 1'b1;
      word.stable_buttons = stable_level;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         if (stable_level[b]) begin
            word.stable_mask[button_sel[b]] = 1'b1;
         end
      end
      return word;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         debounce_ticks_q = DEBOUNCE_RESET;
         guard_ticks_q = GUARD_RESET;
         button_sel[0] = SEL_FIRST_RESET;
         button_sel[1] = SEL_SECOND_RESET;
         button_sel[2] = SEL_CANCEL_RESET;
         started_q = 1'b0;
         cand_level = '0;
         stable_level = '0;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            cand_time[b] = '0;
            last_press[b] = '0;
         end
         button_reports.delete();
         error_count = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DEBOUNCE_TICKS: debounce_ticks_q = csr_write_data;
               CSR_GUARD_TICKS: guard_ticks_q = csr_write_data;
               CSR_SELECT_FIRST: button_sel[0] = csr_write_data[SEL_WIDTH-1:0];
               CSR_SELECT_SECOND: button_sel[1] = csr_write_data[SEL_WIDTH-1:0];
               CSR_SELECT_CANCEL: button_sel[2] = csr_write_data[SEL_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            button_reports.push_back(debounce_sample(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (button_reports.size() == 0) begin
               report_mismatch($sformatf("response word %h with none expected", rsp_data));
            end else begin
               want = button_reports.pop_front();
               if (rsp_data.stable_buttons !== want.stable_buttons)
                  report_mismatch($sformatf("stable_buttons got %h expected %h",
                                            rsp_data.stable_buttons, want.stable_buttons));
               if (rsp_data.stable_mask !== want.stable_mask)
                  report_mismatch($sformatf("stable_mask got %h expected %h",
                                            rsp_data.stable_mask, want.stable_mask));
               if (rsp_data.press_events !== want.press_events)
                  report_mismatch($sformatf("press_events got %h expected %h",
                                            rsp_data.press_events, want.press_events));
               if (rsp_data.release_events !== want.release_events)
                  report_mismatch($sformatf("release_events got %h expected %h",
                                            rsp_data.release_events, want.release_events));
               if (rsp_data.guarded_presses !== want.guarded_presses)
                  report_mismatch($sformatf("guarded_presses got %h expected %h",
                                            rsp_data.guarded_presses, want.guarded_presses));
            end
         end
      end
      pending_words = button_reports.size();
   end

endmodule

/* bench/tb_top.sv */
// Testbench top for the debouncer: clock, reset, stimulus, receiver stalls and the verdict.
`timescale 1ns / 100ps
module tb_top;
   import tbdpg_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data;
   int error_count;
   int pending_words;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_armed = 1'b0;
   int unsigned max_step = 1;
   logic [TICK_WIDTH-1:0] tick = '0;
   logic [SNAP_WIDTH-1:0] held_levels = '0;
   logic [SEL_WIDTH-1:0] sel_shadow [NUM_BUTTONS];

   three_button_debouncer_with_press_guard_core i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   tbdpg_button_checker i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .error_count(error_count),
      .pending_words(pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int held;
      bit hold_done;
      held = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_done) begin
            rsp_ready <= 1'b0;
            held++;
            if (held == 120) hold_done = 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_sample(input logic [SNAP_WIDTH-1:0] snap,
                              input logic [TICK_WIDTH-1:0] now_tick);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{snapshot: snap, now: now_tick};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int unsigned value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[CSR_DATA_WIDTH-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_SELECT_FIRST: sel_shadow[0] = value[SEL_WIDTH-1:0];
         CSR_SELECT_SECOND: sel_shadow[1] = value[SEL_WIDTH-1:0];
         CSR_SELECT_CANCEL: sel_shadow[2] = value[SEL_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input int unsigned debounce, input int unsigned guard,
                               input int unsigned sel0, input int unsigned sel1,
                               input int unsigned sel2);
      write_csr(CSR_DEBOUNCE_TICKS, debounce);
      write_csr(CSR_GUARD_TICKS, guard);
      write_csr(CSR_SELECT_FIRST, sel0);
      write_csr(CSR_SELECT_SECOND, sel1);
      write_csr(CSR_SELECT_CANCEL, sel2);
   endtask

   // Most words follow a slowly changing level with bounces on the selected
   // buttons; a few carry a random snapshot or a random jump of the tick.
   task automatic run_button_traffic(input int count);
      logic [SNAP_WIDTH-1:0] snap;
      int unsigned pick;
      int unsigned bit_pos;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            bit_pos = sel_shadow[$urandom_range(NUM_BUTTONS-1)];
            held_levels[bit_pos] = ~held_levels[bit_pos];
         end else if (pick < 20) begin
            bit_pos = $urandom_range(SNAP_WIDTH-1);
            held_levels[bit_pos] = ~held_levels[bit_pos];
         end
         if ($urandom_range(49) == 0) tick = $urandom;
         else tick = tick + $urandom_range(max_step);
         pick = $urandom_range(99);
         if (pick < 5) snap = 8'($urandom);
         else if (pick < 15) snap = held_levels ^ (8'd1 << sel_shadow[$urandom_range(2)]);
         else snap = held_levels;
         send_sample(snap, tick);
      end
   endtask

   initial begin
      int unsigned deb;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      sel_shadow[0] = SEL_FIRST_RESET;
      sel_shadow[1] = SEL_SECOND_RESET;
      sel_shadow[2] = SEL_CANCEL_RESET;
      send_idle_pct = 35;
      recv_stall_pct = 69;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // The first sample loads levels, then a press lands on tick zero across
      // the wrap, and the following presses probe the guard window.
      apply_config(2, 10, 0, 1, 2);
      send_sample(8'h00, 32'hFFFF_FFFC);
      send_sample(8'hFF, 32'hFFFF_FFFE);
      send_sample(8'hFF, 32'h0000_0000);
      send_sample(8'h00, 32'd1);
      send_sample(8'h00, 32'd3);
      send_sample(8'h07, 32'd4);
      send_sample(8'h07, 32'd6);
      send_sample(8'hF8, 32'd7);
      send_sample(8'hF8, 32'd9);
      send_sample(8'h07, 32'd10);
      send_sample(8'h07, 32'd12);
      send_sample(8'h00, 32'd13);
      send_sample(8'h00, 32'd15);
      send_sample(8'h05, 32'd16);
      send_sample(8'h07, 32'd17);
      send_sample(8'h05, 32'd18);
      send_sample(8'h05, 32'd20);
      send_sample(8'hAA, 32'd21);

      // All buttons share one bit with no debounce and no guard.
      wait_idle();
      apply_config(0, 0, 7, 7, 7);
      send_sample(8'h80, 32'd22);
      send_sample(8'h80, 32'd22);
      send_sample(8'h7F, 32'd23);
      send_sample(8'h7F, 32'd23);
      send_sample(8'hFF, 32'hFFFF_FFFF);
      send_sample(8'h55, 32'hFFFF_FFFF);

      wait_idle();
      apply_config(4, 25, 0, 1, 2);
      max_step = 3;
      run_button_traffic(200);

      wait_idle();
      apply_config(0, 0, 5, 5, 3);
      max_step = 2;
      run_button_traffic(200);

      send_idle_pct = 69;
      recv_stall_pct = 35;
      wait_idle();
      apply_config(65535, 65535, 7, 0, 6);
      max_step = 40000;
      run_button_traffic(200);

      wait_idle();
      apply_config($urandom_range(12), $urandom_range(60), $urandom_range(7),
                   $urandom_range(7), $urandom_range(7));
      max_step = 6;
      run_button_traffic(200);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_idle();
      apply_config(3, 65535, 4, 2, 1);
      max_step = 4;
      hold_armed = 1'b1;
      run_button_traffic(200);

      wait_idle();
      deb = $urandom_range(65535);
      apply_config(deb, $urandom_range(65535),
                   32'({13'($urandom_range(8191)), 3'(sel_shadow[1])}),
                   32'({13'($urandom_range(8191)), 3'($urandom_range(7))}),
                   32'({13'($urandom_range(8191)), 3'($urandom_range(7))}));
      max_step = deb / 2 + 2;
      run_button_traffic(200);

      wait_idle();
      if (error_count == 0 && pending_words == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
